// ----- rtl/sqe_pkg.sv -----
// Shared types, constants and tables of the sprite quad expander.
`default_nettype none
package sqe_pkg;

   // Angles in Q16.16 degrees
   localparam logic [33:0] DEG360      = 34'd23592960;
   localparam logic [33:0] DEG90       = 34'd5898240;
   // Bias that makes any 32-bit angle positive: 92 full turns
   localparam logic [33:0] REDUCE_BIAS = 34'd2170552320;
   localparam int          REDUCE_STEPS = 8;
   localparam int          CORDIC_STEPS = 16;
   // Q2.30 constants
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
   localparam logic [4:0]  SLOT_NONE = 5'h1F;

   // One classified sprite travelling from the front to the back
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] rotation_deg;
      logic [4:0]         tex_slot;
      logic               table_full;
      logic [31:0]        entity_id;
   } item_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic not_full;
      logic not_empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_QUAD,
      ST_CORDIC,
      ST_MUL,
      ST_EMIT
   } back_state_type;

   // Arctangent of 2^-i in Q16.16 degrees
   function automatic logic signed [25:0] atan_q16(input logic [3:0] i);
      logic signed [25:0] r;
      case (i)
         4'd0:    r = 26'sd2949120;
         4'd1:    r = 26'sd1740967;
         4'd2:    r = 26'sd919879;
         4'd3:    r = 26'sd466945;
         4'd4:    r = 26'sd234379;
         4'd5:    r = 26'sd117304;
         4'd6:    r = 26'sd58666;
         4'd7:    r = 26'sd29335;
         4'd8:    r = 26'sd14668;
         4'd9:    r = 26'sd7334;
         4'd10:   r = 26'sd3667;
         4'd11:   r = 26'sd1833;
         4'd12:   r = 26'sd917;
         4'd13:   r = 26'sd458;
         4'd14:   r = 26'sd229;
         default: r = 26'sd115;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/sqe_front.sv -----
// Front: texture handle lookup and classification of each accepted sprite.
`default_nettype none
module sqe_front #(
   parameter int TEXTURE_SLOTS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic               new_batch,
   input  wire logic               has_texture,
   input  wire logic [31:0]        texture_handle,
   input  wire logic signed [31:0] pos_x,
   input  wire logic signed [31:0] pos_y,
   input  wire logic signed [31:0] scale_x,
   input  wire logic signed [31:0] scale_y,
   input  wire logic signed [31:0] rotation_deg,
   input  wire logic [31:0]        entity_id,
   output sqe_pkg::item_type       item
);

   localparam int CNT_W = $clog2(TEXTURE_SLOTS + 1);
   localparam int IDX_W = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;

   logic [31:0]        tex_mem [TEXTURE_SLOTS];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   cnt_eff;
   logic [TEXTURE_SLOTS-1:0] hit;
   logic [4:0]         hit_idx;
   logic               found, full, append;

   // Compare the handle against every valid entry
   assign cnt_eff = new_batch ? '0 : count_ff;
   always_comb begin
      for (int i = 0; i < TEXTURE_SLOTS; i++) begin
         hit[i] = (CNT_W'(i) < cnt_eff) && (tex_mem[i] == texture_handle);
      end
   end

   // Pick the lowest matching slot
   always_comb begin
      hit_idx = '0;
      for (int i = TEXTURE_SLOTS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_idx = 5'(i);
         end
      end
   end

   assign found  = |hit;
   assign full   = (cnt_eff == CNT_W'(TEXTURE_SLOTS));
   assign append = has_texture && !found && !full;

   // Classify the sprite
   always_comb begin
      item.pos_x        = pos_x;
      item.pos_y        = pos_y;
      item.scale_x      = scale_x;
      item.scale_y      = scale_y;
      item.rotation_deg = rotation_deg;
      item.entity_id    = entity_id;
      item.table_full   = 1'b0;
      item.tex_slot     = sqe_pkg::SLOT_NONE;
      if (has_texture) begin
         if (found) begin
            item.tex_slot = hit_idx;
         end else if (!full) begin
            item.tex_slot = 5'(cnt_eff);
         end else begin
            item.table_full = 1'b1;
         end
      end
   end

   // Advance the fill count
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = append ? cnt_eff + CNT_W'(1) : cnt_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Append a new handle
   always_ff @(posedge clock) begin
      if (accept && append) begin
         tex_mem[cnt_eff[IDX_W-1:0]] <= texture_handle;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/sqe_queue.sv -----
// Two-entry queue that decouples the front from the back.
`default_nettype none
module sqe_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire sqe_pkg::item_type    push_item,
   input  wire logic                 pop,
   output sqe_pkg::item_type         pop_item,
   output sqe_pkg::queue_status_type status
);

   sqe_pkg::item_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign status.not_full  = (fill_ff != 2'd2);
   assign status.not_empty = (fill_ff != 2'd0);
   assign pop_item = mem[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the pushed transaction
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/sqe_back.sv -----
// Back: angle reduction, CORDIC, shared multiplier and corner emission.
`default_nettype none
module sqe_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sqe_pkg::queue_status_type status,
   input  wire sqe_pkg::item_type    item,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [103:0]              rsp_tdata,
   output logic                      rsp_tuser,
   output logic                      rsp_tlast
);

   sqe_pkg::back_state_type state_ff, state_in;
   sqe_pkg::item_type       sprite_ff;
   logic [3:0]   step_ff, step_in;
   logic [33:0]  m_ff, m_in;
   logic [1:0]   quad_ff;
   logic         zero_ff;
   logic signed [33:0] x_ff, y_ff;
   logic signed [25:0] z_ff;
   logic signed [63:0] p_cu_ff, p_sv_ff, p_su_ff, p_cv_ff;

   // Output register
   logic         out_valid_ff;
   logic [31:0]  out_x_ff, out_y_ff;
   logic [1:0]   out_corner_ff;
   logic [4:0]   out_slot_ff;
   logic [31:0]  out_entity_ff;
   logic         out_full_ff;
   logic         out_slot_ok;

   logic         out_free, load_out;
   logic         last_step;

   assign out_free = !out_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sqe_pkg::ST_IDLE:   if (status.not_empty) state_in = sqe_pkg::ST_REDUCE;
         sqe_pkg::ST_REDUCE: if (last_step) state_in = sqe_pkg::ST_QUAD;
         sqe_pkg::ST_QUAD:   state_in = sqe_pkg::ST_CORDIC;
         sqe_pkg::ST_CORDIC: if (last_step) state_in = sqe_pkg::ST_MUL;
         sqe_pkg::ST_MUL:    if (last_step) state_in = sqe_pkg::ST_EMIT;
         sqe_pkg::ST_EMIT:   if (last_step && out_free) state_in = sqe_pkg::ST_IDLE;
         default:            state_in = sqe_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      pop       = 1'b0;
      load_out  = 1'b0;
      last_step = 1'b0;
      case (state_ff)
         sqe_pkg::ST_IDLE:   pop = status.not_empty;
         sqe_pkg::ST_REDUCE: last_step = (step_ff == 4'(sqe_pkg::REDUCE_STEPS - 1));
         sqe_pkg::ST_CORDIC: last_step = (step_ff == 4'(sqe_pkg::CORDIC_STEPS - 1));
         sqe_pkg::ST_MUL:    last_step = (step_ff == 4'd3);
         sqe_pkg::ST_EMIT: begin
            last_step = (step_ff == 4'd3);
            load_out  = out_free;
         end
         default: ;
      endcase
   end

   // Step counter
   always_comb begin
      step_in = step_ff + 4'd1;
      if (state_ff == sqe_pkg::ST_IDLE || state_ff == sqe_pkg::ST_QUAD ||
          (last_step && state_ff != sqe_pkg::ST_EMIT)) begin
         step_in = '0;
      end else if (state_ff == sqe_pkg::ST_EMIT && !out_free) begin
         step_in = step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sqe_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Angle reduction: subtract 360 degrees times 2^k, k from seven down
   logic [33:0] turn_k;
   assign turn_k = sqe_pkg::DEG360 << (3'd7 - step_ff[2:0]);
   always_comb begin
      m_in = m_ff;
      if (state_ff == sqe_pkg::ST_IDLE) begin
         m_in = sqe_pkg::REDUCE_BIAS + 34'($signed(item.rotation_deg));
      end else if (state_ff == sqe_pkg::ST_REDUCE && m_ff >= turn_k) begin
         m_in = m_ff - turn_k;
      end
   end

   // Quadrant split
   logic [1:0]  quad_c;
   logic [33:0] rem_c;
   always_comb begin
      if (m_ff >= 3 * sqe_pkg::DEG90) begin
         quad_c = 2'd3;
         rem_c  = m_ff - 3 * sqe_pkg::DEG90;
      end else if (m_ff >= 2 * sqe_pkg::DEG90) begin
         quad_c = 2'd2;
         rem_c  = m_ff - 2 * sqe_pkg::DEG90;
      end else if (m_ff >= sqe_pkg::DEG90) begin
         quad_c = 2'd1;
         rem_c  = m_ff - sqe_pkg::DEG90;
      end else begin
         quad_c = 2'd0;
         rem_c  = m_ff;
      end
   end

   // One CORDIC rotation step
   logic signed [33:0] dx, dy;
   logic signed [25:0] atan_c;
   assign dx     = y_ff >>> step_ff;
   assign dy     = x_ff >>> step_ff;
   assign atan_c = sqe_pkg::atan_q16(step_ff);

   always_ff @(posedge clock) begin
      if (state_ff == sqe_pkg::ST_IDLE && status.not_empty) begin
         sprite_ff <= item;
      end
      m_ff <= m_in;
      if (state_ff == sqe_pkg::ST_QUAD) begin
         quad_ff <= quad_c;
         zero_ff <= (rem_c == '0);
         z_ff    <= 26'(rem_c);
         x_ff    <= sqe_pkg::CORDIC_GAIN;
         y_ff    <= '0;
      end else if (state_ff == sqe_pkg::ST_CORDIC) begin
         if (z_ff >= 0) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - atan_c;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + atan_c;
         end
      end
   end

   // Apply the quadrant by swaps and negations
   logic signed [33:0] bc, bs, cos_c, sin_c;
   always_comb begin
      bc = zero_ff ? sqe_pkg::ONE_Q30 : x_ff;
      bs = zero_ff ? '0 : y_ff;
      case (quad_ff)
         2'd0:    begin cos_c = bc;  sin_c = bs;  end
         2'd1:    begin cos_c = -bs; sin_c = bc;  end
         2'd2:    begin cos_c = -bc; sin_c = -bs; end
         default: begin cos_c = bs;  sin_c = -bc; end
      endcase
   end

   // Shared multiplier: cos*sx, sin*sy, sin*sx, cos*sy in turn
   logic signed [33:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [65:0] mul_p;
   always_comb begin
      case (step_ff[1:0])
         2'd0:    begin mul_a = cos_c; mul_b = sprite_ff.scale_x; end
         2'd1:    begin mul_a = sin_c; mul_b = sprite_ff.scale_y; end
         2'd2:    begin mul_a = sin_c; mul_b = sprite_ff.scale_x; end
         default: begin mul_a = cos_c; mul_b = sprite_ff.scale_y; end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (state_ff == sqe_pkg::ST_MUL) begin
         case (step_ff[1:0])
            2'd0:    p_cu_ff <= 64'(mul_p);
            2'd1:    p_sv_ff <= 64'(mul_p);
            2'd2:    p_su_ff <= 64'(mul_p);
            default: p_cv_ff <= 64'(mul_p);
         endcase
      end
   end

   // Corner offsets in emission order (1,1), (1,0), (0,0), (0,1)
   logic signed [65:0] rx, ry;
   always_comb begin
      case (step_ff[1:0])
         2'd0: begin
            rx = 66'(p_cu_ff) - 66'(p_sv_ff);
            ry = 66'(p_su_ff) + 66'(p_cv_ff);
         end
         2'd1: begin
            rx = 66'(p_cu_ff);
            ry = 66'(p_su_ff);
         end
         2'd2: begin
            rx = '0;
            ry = '0;
         end
         default: begin
            rx = -66'(p_sv_ff);
            ry = 66'(p_cv_ff);
         end
      endcase
   end

   // Round, add the origin, saturate
   function automatic logic [31:0] sat_pos(input logic signed [31:0] origin,
                                           input logic signed [65:0] prod);
      logic signed [65:0] rnd;
      logic signed [36:0] r;
      rnd = (prod + 66'sd536870912) >>> 30;
      r   = 37'(origin) + 37'(rnd);
      if (r > 37'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end else if (r < -37'sd2147483648) begin
         return 32'h8000_0000;
      end
      return r[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Capture the whole corner, so a waiting corner holds while the next sprite loads
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_x_ff      <= sat_pos(sprite_ff.pos_x, rx);
         out_y_ff      <= sat_pos(sprite_ff.pos_y, ry);
         out_corner_ff <= step_ff[1:0];
         out_slot_ff   <= sprite_ff.tex_slot;
         out_entity_ff <= sprite_ff.entity_id;
         out_full_ff   <= sprite_ff.table_full;
      end
   end

   assign out_slot_ok = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_entity_ff, out_slot_ff,
                        out_corner_ff, out_y_ff, out_x_ff} & {104{out_slot_ok}};
   assign rsp_tuser  = out_full_ff;
   assign rsp_tlast  = (out_corner_ff == 2'd3);

endmodule
`default_nettype wire

// ----- rtl/sprite_quad_expander_unit.sv -----
// Top level of the sprite quad expander.
//
// Input channel req_*: one sprite per transaction. Output channel rsp_*: four
// quad corners per sprite, in the order (1,1), (1,0), (0,0), (0,1); rsp_tlast
// marks the fourth. A texture handle is looked up in a table of TEXTURE_SLOTS
// entries as the sprite is accepted and appended if new; new_batch empties the
// table first. A full table gives slot -1 and raises rsp_tuser.
// A two-entry queue sits between lookup and geometry, so up to two sprites
// are taken while the back is busy.
// The back takes one sprite at a time and pops the next only after its last
// corner is loaded; its sequencer runs a pop, 8 angle reduction steps, a
// quadrant step, 16 CORDIC steps, 4 passes through the single multiplier and
// 4 corners, and stalls on its corners while the receiver does not keep up.
// When the receiver stalls, the corner in the output register holds and the
// back waits; the front keeps accepting until the queue is full.
// Reset empties the queue and the texture table and returns the back to idle.
`default_nettype none
module sprite_quad_expander_unit #(
   parameter int TEXTURE_SLOTS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // pos_x, pos_y, scale_x, scale_y, rotation_deg, texture_handle, entity_id
   input  wire logic [223:0] req_tdata,
   // new_batch, has_texture
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // vert_x, vert_y, corner, tex_slot, vertex_entity, zero pad
   output logic [103:0]      rsp_tdata,
   // table_full
   output logic              rsp_tuser,
   output logic              rsp_tlast
);

   sqe_pkg::item_type        push_item, pop_item;
   sqe_pkg::queue_status_type status;
   logic accept, pop;

   assign req_tready = status.not_full;
   assign accept     = req_tvalid && status.not_full;

   // Classify and look up the texture
   sqe_front #(.TEXTURE_SLOTS(TEXTURE_SLOTS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .new_batch      (req_tuser[0]),
      .has_texture    (req_tuser[1]),
      .texture_handle (req_tdata[191:160]),
      .pos_x          (req_tdata[31:0]),
      .pos_y          (req_tdata[63:32]),
      .scale_x        (req_tdata[95:64]),
      .scale_y        (req_tdata[127:96]),
      .rotation_deg   (req_tdata[159:128]),
      .entity_id      (req_tdata[223:192]),
      .item           (push_item)
   );

   // Hold classified sprites
   sqe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (status)
   );

   // Compute and emit the corners
   sqe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .item       (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTH
   // Last flag goes with the fourth corner only
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[65:64] == 2'd3)))
      else $error("tlast does not match corner number");

   // A full table always reports slot -1
   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[70:66] == 5'h1F))
      else $error("table full without slot -1");

   // Queue is never popped while empty
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> status.not_empty)
      else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire
